// ----- src/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

	typedef logic signed [31:0] word_t;

	// Request opcodes
	localparam logic [2:0] OP_INS_HEAD = 3'd0;
	localparam logic [2:0] OP_INS_TAIL = 3'd1;
	localparam logic [2:0] OP_INS_POS  = 3'd2;
	localparam logic [2:0] OP_DEL_HEAD = 3'd3;
	localparam logic [2:0] OP_DEL_TAIL = 3'd4;
	localparam logic [2:0] OP_DEL_POS  = 3'd5;
	localparam logic [2:0] OP_DUMP     = 3'd6;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BOUNDS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [2:0] opcode;
		logic [5:0] position;
		word_t      value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		word_t      item_value;
		logic       has_item;
		logic       is_last;
	} rsp_t;

	// The command that every cell of the chain carries out
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_DELETE,
		CMD_ROTATE
	} cmd_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

endpackage

// ----- src/ple_cell.sv -----
// One storage cell of the list chain.
`timescale 1ns / 1ps

module ple_cell import ple_pkg::*; #(
	parameter int INDEX = 0,
	parameter int LW    = 6
) (
	input  logic            clk,
	input  cmd_kind_t       kind,
	input  logic [LW-1:0]   idx,
	input  logic [LW-1:0]   len,
	input  word_t           new_value,
	input  word_t           left,
	input  word_t           right,
	input  word_t           head,
	output word_t           value
);

	localparam logic [LW-1:0] MY_IDX  = LW'(INDEX);
	localparam logic [LW-1:0] MY_NEXT = LW'(INDEX + 1);

	word_t value_q;
	word_t value_d;

	always_comb begin
		value_d = value_q;
		unique case (kind)
			CMD_INSERT: begin
				if (MY_IDX == idx) begin
					value_d = new_value;
				end else if (MY_IDX > idx) begin
					value_d = left;
				end
			end
			CMD_DELETE: begin
				if (MY_IDX >= idx) begin
					value_d = right;
				end
			end
			CMD_ROTATE: begin
				// advance toward the head; the tail slot takes the old head
				if (MY_NEXT < len) begin
					value_d = right;
				end else if (MY_NEXT == len) begin
					value_d = head;
				end
			end
			CMD_HOLD: value_d = value_q;
			default:  value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

// ----- src/positional_list_engine.sv -----
// Top level of the positional list engine: control, length and the cell chain.
`timescale 1ns / 1ps

// Positional list engine: a bounded ordered list of signed 32-bit values.
// The request channel (req_valid / req_stall / req) carries an opcode, a
// 1-based position and a value. The result channel (rsp_valid / rsp_stall /
// rsp) returns status, item_value, has_item and is_last.
// The list lives in a chain of CAPACITY cells; an insert or delete shifts
// every affected cell by one place at once.
// A request is registered on acceptance and executed in the EXEC state
// once the result register is free to load; req_stall stays high until the
// engine is back in idle, so no new request is taken while one is in work.
// A dump of a non-empty list goes from EXEC to DUMP, then rotates the chain
// by one cell per cycle while the receiver does not stall, presenting the
// head cell each time. The rotation leaves the list in its original order.
// Opcode 7 is dropped with no result.
// Reset clears the length and the control state; cell contents are left as
// they are and are never read before being written.
// When the receiver stalls, the result register holds and the engine waits
// in its current step; a new request is still taken while a finished result
// waits, as long as the engine itself is idle.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > 6) ? LW : 6) + 1;

	state_t          state_q, state_d;
	req_t            req_q;
	logic [LW-1:0]   len_q, len_d;
	logic [LW-1:0]   cnt_q, cnt_d;
	logic            rsp_valid_q;
	rsp_t            rsp_q, rsp_d;
	logic            load;
	logic            can_load;

	cmd_kind_t       kind;
	logic [LW-1:0]   idx;

	// decoded edit of the held request
	logic [1:0]      st;
	cmd_kind_t       ek;
	logic [LW-1:0]   eidx;
	logic [CW-1:0]   pos_w, len_w;
	logic            full, empty;

	word_t cell_val [CAPACITY];

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign can_load  = !rsp_valid_q || !rsp_stall;

	// Status and shift decode for the held request
	always_comb begin
		pos_w = CW'(req_q.position);
		len_w = CW'(len_q);
		full  = (len_q == LW'(CAPACITY));
		empty = (len_q == '0);
		st    = ST_OK;
		ek    = CMD_HOLD;
		eidx  = '0;
		unique case (req_q.opcode)
			OP_INS_HEAD: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ek = CMD_INSERT;
				end
			end
			OP_INS_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ek   = CMD_INSERT;
					eidx = len_q;
				end
			end
			OP_INS_POS: begin
				if (full) begin
					st = ST_FULL;
				end else if (pos_w == '0 || pos_w > len_w + CW'(1)) begin
					st = ST_BOUNDS;
				end else begin
					ek   = CMD_INSERT;
					eidx = LW'(pos_w - CW'(1));
				end
			end
			OP_DEL_HEAD: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					ek = CMD_DELETE;
				end
			end
			OP_DEL_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					ek   = CMD_DELETE;
					eidx = len_q - LW'(1);
				end
			end
			OP_DEL_POS: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (pos_w == '0 || pos_w > len_w) begin
					st = ST_BOUNDS;
				end else begin
					ek   = CMD_DELETE;
					eidx = LW'(pos_w - CW'(1));
				end
			end
			default: begin
				// dump and the unused opcode make no edit
				st = ST_OK;
				ek = CMD_HOLD;
			end
		endcase
	end

	// Sequencer: next state, chain command and result load
	always_comb begin
		state_d = state_q;
		kind    = CMD_HOLD;
		idx     = '0;
		load    = 1'b0;
		rsp_d   = '0;
		len_d   = len_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (can_load) begin
					state_d = S_IDLE;
					if (req_q.opcode == OP_DUMP) begin
						if (empty) begin
							load          = 1'b1;
							rsp_d.status  = ST_OK;
							rsp_d.is_last = 1'b1;
						end else begin
							cnt_d   = '0;
							state_d = S_DUMP;
						end
					end else if (req_q.opcode <= OP_DEL_POS) begin
						load          = 1'b1;
						rsp_d.status  = st;
						rsp_d.is_last = 1'b1;
						if (st == ST_OK) begin
							kind = ek;
							idx  = eidx;
							if (ek == CMD_INSERT) begin
								len_d = len_q + LW'(1);
							end else if (ek == CMD_DELETE) begin
								len_d = len_q - LW'(1);
							end
						end
					end
				end
			end
			S_DUMP: begin
				if (can_load) begin
					load             = 1'b1;
					rsp_d.status     = ST_OK;
					rsp_d.item_value = cell_val[0];
					rsp_d.has_item   = 1'b1;
					rsp_d.is_last    = (cnt_q == len_q - LW'(1));
					kind             = CMD_ROTATE;
					cnt_d            = cnt_q + LW'(1);
					if (rsp_d.is_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: capture the request on accept, the result on load
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	// Cell chain: each cell sees its neighbors and the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_v, right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		ple_cell #(
			.INDEX (i),
			.LW    (LW)
		) u_cell (
			.clk       (clk),
			.kind      (kind),
			.idx       (idx),
			.len       (len_q),
			.new_value (req_q.value),
			.left      (left_v),
			.right     (right_v),
			.head      (cell_val[0]),
			.value     (cell_val[i])
		);
	end

endmodule

// ----- src/ple_checker.sv -----
// Port-level checks for the positional list engine, bound to the top level.
`timescale 1ns / 1ps

module ple_checker import ple_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled result changed");

	a_no_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_item |-> rsp.item_value == '0)
		else $error("item value set on a result without an entry");

	a_no_item_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_item |-> rsp.is_last)
		else $error("single result not marked last");

	a_item_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.has_item |-> rsp.status == ST_OK)
		else $error("dump entry with error status");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
